FILE: src/pss_pkg.sv
// Package for the positional sequence store: sizes, opcodes, status codes
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package pss_pkg;

	localparam int CAP = 64;
	localparam int AW  = $clog2(CAP);
	localparam int LW  = $clog2(CAP + 1);
	localparam int DW  = 32;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_ERASE   = 3'd1,
		OP_SWAP    = 3'd2,
		OP_MOVE    = 3'd3,
		OP_QUERY   = 3'd4,
		OP_READALL = 3'd5
	} op_t;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic          load;
		logic          fwd;
		logic          back;
		logic          rd;
		logic          rd_last;
		logic          put;
		logic          len_inc;
		logic          len_dec;
		logic          emit;
		logic          emit_neg;
		logic [1:0]    emit_status;
		logic [AW-1:0] k;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0]    op;
		logic [LW-1:0] len;
		logic [LW-1:0] pos;
		logic [LW-1:0] tot;
		logic          pos_ok;
		logic          mv_ok;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: src/pss_ctrl.sv
// Controller for the positional sequence store: decodes the latched
// operation and walks index ranges. Depends on pss_pkg.
`default_nettype none
module pss_ctrl import pss_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  dp_stat_t      stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DEC   = 8'b0000_0010,
		S_FWD   = 8'b0000_0100,
		S_DRF   = 8'b0000_1000,
		S_BACK  = 8'b0001_0000,
		S_DRB   = 8'b0010_0000,
		S_FIN   = 8'b0100_0000,
		S_RDALL = 8'b1000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [LW-1:0] k_q, k_d, lo_q, lo_d, hi_q, hi_d, k_inc;

	assign busy  = (state_q != S_IDLE);
	assign k_inc = k_q + LW'(1);

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		cmd     = '0;
		cmd.k   = k_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) state_d = S_DEC;
			end
			S_DEC: begin
				state_d = S_IDLE;
				case (stat.op)
					OP_INSERT: begin
						lo_d = stat.pos + LW'(1);
						hi_d = stat.len + LW'(1);
						if (stat.pos > stat.len) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_RANGE;
						end else if (stat.len == LW'(CAP)) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_FULL;
						end else begin
							state_d = (lo_d >= hi_d) ? S_FIN : S_FWD;
						end
					end
					OP_ERASE: begin
						lo_d = stat.pos - LW'(1);
						hi_d = stat.len - LW'(1);
						if (!stat.pos_ok) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_RANGE;
						end else begin
							state_d = (lo_d >= hi_d) ? S_FIN : S_FWD;
						end
					end
					OP_SWAP: begin
						lo_d = '0;
						hi_d = {stat.len[LW-1:1], 1'b0};
						state_d = (hi_d == '0) ? S_FIN : S_FWD;
					end
					OP_MOVE: begin
						lo_d = '0;
						hi_d = stat.tot;
						if (!stat.mv_ok) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_RANGE;
						end else begin
							state_d = S_FWD;
						end
					end
					OP_QUERY: begin
						if (!stat.pos_ok) begin
							cmd.emit = 1'b1;
							cmd.emit_neg = 1'b1;
							cmd.emit_status = ST_RANGE;
						end else begin
							cmd.rd = 1'b1;
							cmd.rd_last = 1'b1;
							cmd.k = AW'(stat.pos - LW'(1));
						end
					end
					OP_READALL: begin
						if (stat.len == '0) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_EMPTY;
						end else begin
							state_d = S_RDALL;
						end
					end
					default: begin
						cmd.emit = 1'b1;
						cmd.emit_status = ST_RANGE;
					end
				endcase
				k_d = (stat.op == OP_READALL) ? '0 : lo_d;
			end
			S_FWD: begin
				cmd.fwd = 1'b1;
				k_d = k_inc;
				if (k_inc == hi_q) state_d = S_DRF;
			end
			// let the last copy land before reading it back
			S_DRF: begin
				k_d = lo_q;
				state_d = S_BACK;
			end
			S_BACK: begin
				cmd.back = 1'b1;
				k_d = k_inc;
				if (k_inc == hi_q) state_d = S_DRB;
			end
			S_DRB: state_d = S_FIN;
			S_FIN: begin
				cmd.emit = 1'b1;
				cmd.emit_status = ST_DONE;
				cmd.put = (stat.op == OP_INSERT);
				cmd.len_inc = (stat.op == OP_INSERT);
				cmd.len_dec = (stat.op == OP_ERASE);
				state_d = S_IDLE;
			end
			S_RDALL: begin
				cmd.rd = 1'b1;
				cmd.rd_last = (k_inc == stat.len);
				k_d = k_inc;
				if (k_inc == stat.len) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/pss_dp.sv
// Datapath for the positional sequence store: element memory, scratch
// memory, copy pipeline, length and result registers. Depends on pss_pkg.
`default_nettype none
module pss_dp import pss_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [2:0]    opcode,
	input  wire logic [6:0]    position,
	input  wire logic [DW-1:0] value,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic               result_valid,
	output logic [DW-1:0]      data,
	output logic [1:0]         status,
	output logic               last
);

	logic [DW-1:0] mem_a [CAP];
	logic [DW-1:0] mem_b [CAP];

	logic [2:0]    op_q;
	logic [LW-1:0] pos_q, len_q;
	logic [DW-1:0] val_q;

	logic          fwd_v_s1, back_v_s1, rd_v_s1, rd_last_s1;
	logic [AW-1:0] k_s1;
	logic [DW-1:0] rda_s1, rdb_s1;

	logic          emit_q;
	logic [DW-1:0] edata_q;
	logic [1:0]    estat_q;

	logic [LW-1:0] tot, rot;
	logic [AW-1:0] src, a_raddr;

	assign tot = pos_q + val_q[LW-1:0];

	assign stat.op     = op_q;
	assign stat.len    = len_q;
	assign stat.pos    = pos_q;
	assign stat.tot    = tot;
	assign stat.pos_ok = (pos_q != '0) && (pos_q <= len_q);
	assign stat.mv_ok  = (pos_q != '0) && (val_q[DW-1:LW] == '0)
		&& (val_q[LW-1:0] != '0)
		&& ({1'b0, pos_q} + {1'b0, val_q[LW-1:0]} <= {1'b0, len_q});

	// source index of each copied entry, per operation
	always_comb begin
		rot = {1'b0, cmd.k} + pos_q;
		if (rot >= tot) rot = rot - tot;
		case (op_q)
			OP_INSERT: src = cmd.k - AW'(1);
			OP_ERASE:  src = cmd.k + AW'(1);
			OP_SWAP:   src = cmd.k ^ AW'(1);
			OP_MOVE:   src = rot[AW-1:0];
			default:   src = cmd.k;
		endcase
	end
	assign a_raddr = cmd.fwd ? src : cmd.k;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			pos_q <= position;
			val_q <= value;
		end
		if (cmd.fwd || cmd.rd) rda_s1 <= mem_a[a_raddr];
		if (cmd.back) rdb_s1 <= mem_b[cmd.k];
		k_s1 <= cmd.k;
		rd_last_s1 <= cmd.rd_last;
		if (back_v_s1) mem_a[k_s1] <= rdb_s1;
		else if (cmd.put) mem_a[pos_q[AW-1:0]] <= val_q;
		if (fwd_v_s1) mem_b[k_s1] <= rda_s1;
		edata_q <= cmd.emit_neg ? '1 : '0;
		estat_q <= cmd.emit_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_s1  <= 1'b0;
			back_v_s1 <= 1'b0;
			rd_v_s1   <= 1'b0;
			emit_q    <= 1'b0;
			len_q     <= '0;
		end else begin
			fwd_v_s1  <= cmd.fwd;
			back_v_s1 <= cmd.back;
			rd_v_s1   <= cmd.rd;
			emit_q    <= cmd.emit;
			if (cmd.len_inc) len_q <= len_q + LW'(1);
			else if (cmd.len_dec) len_q <= len_q - LW'(1);
		end
	end

	assign result_valid = rd_v_s1 | emit_q;
	assign data         = rd_v_s1 ? rda_s1 : edata_q;
	assign status       = rd_v_s1 ? ST_DONE : estat_q;
	assign last         = rd_v_s1 ? rd_last_s1 : 1'b1;

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAP)) else $error("length above capacity");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_v_s1 && emit_q)) else $error("two results in one cycle");
	a_a_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(back_v_s1 && cmd.put)) else $error("element write port conflict");
	a_copy_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.back |-> !fwd_v_s1) else $error("scratch read before copy landed");

endmodule
`default_nettype wire

FILE: src/positional_sequence_store_unit.sv
// Channel   Signals                                   Transfer
// command   start, busy, opcode, position, value      start && !busy
// result    result_valid, data, status, last          result_valid, one cycle
//
// Query and out-of-range items: the result is registered straight from the decode state.
// Insert, erase, swap, move-back: two copy passes through a scratch memory
// for the moved entries (one memory port each way).
// Read-all: one element per cycle.
// Reset clears length and control state, not the memories; the receiver cannot stall results.
// Top level; depends on pss_pkg, pss_ctrl and pss_dp.
`default_nettype none
module positional_sequence_store_unit import pss_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire logic [2:0]    opcode,
	input  wire logic [6:0]    position,
	input  wire logic [DW-1:0] value,
	output logic               result_valid,
	output logic [DW-1:0]      data,
	output logic [1:0]         status,
	output logic               last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	pss_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.position     (position),
		.value        (value),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.data         (data),
		.status       (status),
		.last         (last)
	);

endmodule
`default_nettype wire
